FILE: rtl/crt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-moduli CRT solver.
// No dependencies; every other file but crt_div uses this package.
package crt_pkg;

    localparam int MODULUS_BITS = 32;
    localparam int FIELD_W      = 32;
    localparam int WIDE_W       = 64;
    localparam int IN_DATA_W    = 4 * FIELD_W;
    localparam int OUT_DATA_W   = 2 * WIDE_W;

    typedef enum logic [3:0] {
        OP_RED_A,
        OP_RED_B,
        OP_GCD,
        OP_NR,
        OP_MR,
        OP_LCM,
        OP_AG,
        OP_BG,
        OP_DQ,
        OP_DR,
        OP_INV0,
        OP_INVQ,
        OP_INVM,
        OP_TMUL,
        OP_TDIV,
        OP_SOL
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_GCD,
        S_NR,
        S_MR,
        S_LCM,
        S_AG,
        S_BG,
        S_CHK,
        S_DQ,
        S_DR,
        S_INV_SEL,
        S_INV0,
        S_INVQ,
        S_INVM,
        S_TMUL,
        S_TDIV,
        S_SOL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic commit;
        logic finish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic q_zero;
        logic mismatch;
        logic mr_le1;
        logic out_full;
    } stat_t;

endpackage

FILE: rtl/two_moduli_crt_solver_core.sv
`timescale 1ns / 1ps
// Top level of the two-moduli CRT solver: sequencer plus datapath.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
//
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tdata: residue_first, modulus_first, residue_second, modulus_second
// m_axis   out  tdata: solution, combined_modulus; tuser: solvable
//
// Each division step, the final 2*MODULUS_BITS-bit reduction included, runs on the one
// serial divider, and each multiply on the one shared multiplier; one item at a time.
// A new beat is taken while a finished result waits in the output register.
// Reset is asynchronous, active low, and leaves the block idle.
module two_moduli_crt_solver_core #(
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // residue_first, modulus_first, residue_second, modulus_second
    input  logic [crt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // solution, combined_modulus
    output logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // solvable
    output logic [0:0]                     m_axis_tuser
);

    crt_pkg::cmd_t  cmd;
    crt_pkg::stat_t st;

    crt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    crt_datapath #(.W(MODULUS_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_data      (s_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_solvable (m_axis_tuser[0])
    );

endmodule

FILE: rtl/crt_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Short mode divides a W-bit dividend, long mode a 2W-bit one; uses no package.
module crt_div #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           long_mode,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           done,
    output logic [2*W-1:0] quotient,
    output logic [W-1:0]   remainder
);

    localparam int CW = $clog2(2 * W + 1);

    logic [2*W-1:0] dd_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;

    assign trial = {rem_reg, dd_reg[2*W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= long_mode ? CW'(2 * W) : CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dd_reg  <= long_mode ? dividend : {dividend[W-1:0], {W{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[W-1:0] : trial[W-1:0];
            dd_reg  <= {dd_reg[2*W-2:0], qbit};
        end
    end

    assign done      = done_reg;
    assign quotient  = dd_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/crt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the CRT solver: operand registers, shared multiplier, output register.
// Depends on crt_pkg and crt_div.
module crt_datapath #(
    parameter int W = crt_pkg::MODULUS_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crt_pkg::cmd_t                  cmd,
    output crt_pkg::stat_t                 st,
    input  logic [crt_pkg::IN_DATA_W-1:0]  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [crt_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_solvable
);

    localparam int SW = W + 2;
    localparam int PW = 2 * SW;
    localparam int FW = crt_pkg::FIELD_W;

    logic [W-1:0] a_reg, n_reg, b_reg, m_reg, p_reg, q_reg;
    logic [W-1:0] nr_reg, mr_reg, ag_reg, dq_reg, d_reg, qq_reg, t_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic signed [PW-1:0] prod_reg;
    logic [2*W-1:0] lcm_reg, sol_reg;
    logic mismatch_reg, mul_done_reg;
    logic out_valid_reg, out_solvable_reg;
    logic [crt_pkg::WIDE_W-1:0] out_sol_reg, out_lcm_reg;

    logic is_mul;
    logic div_long, div_done;
    logic [2*W-1:0] div_dvd, div_quo;
    logic [W-1:0] div_dvs, div_rem, diff_ab, fa, fn, fb, fm;
    logic signed [SW-1:0] ma, mb, inv;

    assign fa = in_data[W-1:0];
    assign fn = in_data[FW+W-1:FW];
    assign fb = in_data[2*FW+W-1:2*FW];
    assign fm = in_data[3*FW+W-1:3*FW];

    assign is_mul = (cmd.op == crt_pkg::OP_LCM) || (cmd.op == crt_pkg::OP_INVM) ||
                    (cmd.op == crt_pkg::OP_TMUL) || (cmd.op == crt_pkg::OP_SOL);
    assign diff_ab = (b_reg >= a_reg) ? (b_reg - a_reg) : (a_reg - b_reg);

    always_comb
    begin
        if (mr_reg <= W'(1))
            inv = '0;
        else if (s0_reg < 0)
            inv = s0_reg + $signed({2'b00, mr_reg});
        else
            inv = s0_reg;
    end

    always_comb
    begin
        div_long = 1'b0;
        div_dvd  = {{W{1'b0}}, a_reg};
        div_dvs  = n_reg;
        case (cmd.op)
            crt_pkg::OP_RED_B: begin div_dvd = {{W{1'b0}}, b_reg};   div_dvs = m_reg;  end
            crt_pkg::OP_GCD:   begin div_dvd = {{W{1'b0}}, p_reg};   div_dvs = q_reg;  end
            crt_pkg::OP_NR:    begin div_dvd = {{W{1'b0}}, n_reg};   div_dvs = p_reg;  end
            crt_pkg::OP_MR:    begin div_dvd = {{W{1'b0}}, m_reg};   div_dvs = p_reg;  end
            crt_pkg::OP_AG:    begin div_dvd = {{W{1'b0}}, a_reg};   div_dvs = p_reg;  end
            crt_pkg::OP_BG:    begin div_dvd = {{W{1'b0}}, b_reg};   div_dvs = p_reg;  end
            crt_pkg::OP_DQ:    begin div_dvd = {{W{1'b0}}, diff_ab}; div_dvs = p_reg;  end
            crt_pkg::OP_DR:    begin div_dvd = {{W{1'b0}}, dq_reg};  div_dvs = mr_reg; end
            crt_pkg::OP_INV0:  begin div_dvd = {{W{1'b0}}, nr_reg};  div_dvs = mr_reg; end
            crt_pkg::OP_INVQ:  begin div_dvd = {{W{1'b0}}, p_reg};   div_dvs = q_reg;  end
            crt_pkg::OP_TDIV:
            begin
                div_dvd  = prod_reg[2*W-1:0];
                div_dvs  = mr_reg;
                div_long = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ma = $signed({2'b00, n_reg});
        mb = $signed({2'b00, mr_reg});
        case (cmd.op)
            crt_pkg::OP_INVM: begin ma = $signed({2'b00, qq_reg}); mb = s1_reg; end
            crt_pkg::OP_TMUL: begin ma = $signed({2'b00, d_reg});  mb = inv;    end
            crt_pkg::OP_SOL:  begin mb = $signed({2'b00, t_reg}); end
            default: ;
        endcase
    end

    crt_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start && !is_mul),
        .long_mode (div_long),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start && is_mul)
            prod_reg <= ma * mb;
        if (cmd.load)
        begin
            a_reg <= fa;
            b_reg <= fb;
            n_reg <= (fn == '0) ? W'(1) : fn;
            m_reg <= (fm == '0) ? W'(1) : fm;
        end
        if (cmd.commit)
        begin
            case (cmd.op)
                crt_pkg::OP_RED_A: a_reg <= div_rem;
                crt_pkg::OP_RED_B:
                begin
                    b_reg <= div_rem;
                    p_reg <= n_reg;
                    q_reg <= m_reg;
                end
                crt_pkg::OP_GCD:
                begin
                    p_reg <= q_reg;
                    q_reg <= div_rem;
                end
                crt_pkg::OP_NR:  nr_reg <= div_quo[W-1:0];
                crt_pkg::OP_MR:  mr_reg <= div_quo[W-1:0];
                crt_pkg::OP_LCM: lcm_reg <= prod_reg[2*W-1:0];
                crt_pkg::OP_AG:  ag_reg <= div_rem;
                crt_pkg::OP_BG:  mismatch_reg <= (div_rem != ag_reg);
                crt_pkg::OP_DQ:  dq_reg <= div_quo[W-1:0];
                crt_pkg::OP_DR:
                    d_reg <= ((b_reg >= a_reg) || (div_rem == '0)) ? div_rem
                                                                   : (mr_reg - div_rem);
                crt_pkg::OP_INV0:
                begin
                    p_reg  <= mr_reg;
                    q_reg  <= div_rem;
                    s0_reg <= '0;
                    s1_reg <= SW'(1);
                end
                crt_pkg::OP_INVQ:
                begin
                    qq_reg <= div_quo[W-1:0];
                    p_reg  <= q_reg;
                    q_reg  <= div_rem;
                end
                crt_pkg::OP_INVM:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg - $signed(prod_reg[SW-1:0]);
                end
                crt_pkg::OP_TDIV: t_reg <= div_rem;
                crt_pkg::OP_SOL:  sol_reg <= {{W{1'b0}}, a_reg} + prod_reg[2*W-1:0];
                default: ;
            endcase
        end
        if (cmd.finish)
        begin
            out_sol_reg      <= mismatch_reg ? '0 : crt_pkg::WIDE_W'(sol_reg);
            out_lcm_reg      <= crt_pkg::WIDE_W'(lcm_reg);
            out_solvable_reg <= !mismatch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_done_reg <= cmd.start && is_mul;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.done     = div_done || mul_done_reg;
    assign st.q_zero   = (q_reg == '0);
    assign st.mismatch = mismatch_reg;
    assign st.mr_le1   = (mr_reg <= W'(1));
    assign st.out_full = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign out_data     = {out_lcm_reg, out_sol_reg};
    assign out_solvable = out_solvable_reg;

endmodule

FILE: rtl/crt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the CRT solver: walks the reduce, gcd, inverse and combine steps.
// Depends on crt_pkg.
module crt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  crt_pkg::stat_t st,
    output crt_pkg::cmd_t  cmd
);

    crt_pkg::state_t state_reg, state_next;
    logic            phase_reg, phase_next;
    logic            is_step;
    crt_pkg::op_t    op;
    crt_pkg::state_t nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crt_pkg::S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = crt_pkg::OP_RED_A;
        state_next = state_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        is_step    = 1'b0;
        op         = crt_pkg::OP_RED_A;
        nxt        = crt_pkg::S_IDLE;
        case (state_reg)
            crt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = crt_pkg::S_RED_A;
                end
            end
            crt_pkg::S_RED_A: begin is_step = 1'b1; op = crt_pkg::OP_RED_A; nxt = crt_pkg::S_RED_B; end
            crt_pkg::S_RED_B: begin is_step = 1'b1; op = crt_pkg::OP_RED_B; nxt = crt_pkg::S_GCD; end
            crt_pkg::S_GCD:
            begin
                if (!phase_reg && st.q_zero)
                    state_next = crt_pkg::S_NR;
                else
                begin
                    is_step = 1'b1;
                    op      = crt_pkg::OP_GCD;
                    nxt     = crt_pkg::S_GCD;
                end
            end
            crt_pkg::S_NR:  begin is_step = 1'b1; op = crt_pkg::OP_NR;  nxt = crt_pkg::S_MR;  end
            crt_pkg::S_MR:  begin is_step = 1'b1; op = crt_pkg::OP_MR;  nxt = crt_pkg::S_LCM; end
            crt_pkg::S_LCM: begin is_step = 1'b1; op = crt_pkg::OP_LCM; nxt = crt_pkg::S_AG;  end
            crt_pkg::S_AG:  begin is_step = 1'b1; op = crt_pkg::OP_AG;  nxt = crt_pkg::S_BG;  end
            crt_pkg::S_BG:  begin is_step = 1'b1; op = crt_pkg::OP_BG;  nxt = crt_pkg::S_CHK; end
            crt_pkg::S_CHK:
                state_next = st.mismatch ? crt_pkg::S_DONE : crt_pkg::S_DQ;
            crt_pkg::S_DQ:  begin is_step = 1'b1; op = crt_pkg::OP_DQ;  nxt = crt_pkg::S_DR;  end
            crt_pkg::S_DR:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_DR;
                nxt     = crt_pkg::S_INV_SEL;
            end
            crt_pkg::S_INV_SEL:
                state_next = st.mr_le1 ? crt_pkg::S_TMUL : crt_pkg::S_INV0;
            crt_pkg::S_INV0:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_INV0;
                nxt     = crt_pkg::S_INVQ;
            end
            crt_pkg::S_INVQ:
            begin
                if (!phase_reg && st.q_zero)
                    state_next = crt_pkg::S_TMUL;
                else
                begin
                    is_step = 1'b1;
                    op      = crt_pkg::OP_INVQ;
                    nxt     = crt_pkg::S_INVM;
                end
            end
            crt_pkg::S_INVM:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_INVM;
                nxt     = crt_pkg::S_INVQ;
            end
            crt_pkg::S_TMUL:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_TMUL;
                nxt     = crt_pkg::S_TDIV;
            end
            crt_pkg::S_TDIV:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_TDIV;
                nxt     = crt_pkg::S_SOL;
            end
            crt_pkg::S_SOL:
            begin
                is_step = 1'b1;
                op      = crt_pkg::OP_SOL;
                nxt     = crt_pkg::S_DONE;
            end
            crt_pkg::S_DONE:
            begin
                if (!st.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = crt_pkg::S_IDLE;
                end
            end
            default: state_next = crt_pkg::S_IDLE;
        endcase

        if (is_step)
        begin
            cmd.op = op;
            if (!phase_reg)
            begin
                cmd.start  = 1'b1;
                phase_next = 1'b1;
            end
            else if (st.done)
            begin
                cmd.commit = 1'b1;
                phase_next = 1'b0;
                state_next = nxt;
            end
        end
    end

endmodule

FILE: rtl/crt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the two-moduli CRT solver, bound to the top level.
// Depends on crt_pkg and two_moduli_crt_solver_core.
module crt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [0:0]                     m_axis_tuser
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on two cycles in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_unsolvable_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
        else $error("unsolvable beat carries a nonzero solution");

    a_lcm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[127:64] != 64'd0)
        else $error("combined modulus is zero");

    a_solution_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] < m_axis_tdata[127:64])
        else $error("solution not below combined modulus");

endmodule

bind two_moduli_crt_solver_core crt_checker u_crt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/crt_scoreboard.sv
`timescale 1ns / 1ps
// Checker for the two-moduli CRT solver: watches both stream channels,
// predicts each result from the accepted input beat and compares. Depends on crt_pkg.
module crt_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [crt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [0:0]                     m_axis_tuser,
    output int                             errors,
    output int                             pending
);

    typedef struct packed {
        logic [crt_pkg::WIDE_W-1:0] solution;
        logic                       solvable;
        logic [crt_pkg::WIDE_W-1:0] lcm;
    } crt_answer_t;

    crt_answer_t answers[$];

    function automatic logic [crt_pkg::WIDE_W-1:0] gcd64(logic [crt_pkg::WIDE_W-1:0] p,
                                                         logic [crt_pkg::WIDE_W-1:0] q);
        logic [crt_pkg::WIDE_W-1:0] r;
        while (q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    function automatic logic [crt_pkg::WIDE_W-1:0] mod_inverse(
        logic [crt_pkg::WIDE_W-1:0] v,
        logic [crt_pkg::WIDE_W-1:0] md);
        longint r0, r1, s0, s1, q, tr, ts;
        if (md <= 1)
            return 0;
        r0 = md;
        r1 = v % md;
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            tr = r0 - q * r1;
            ts = s0 - q * s1;
            r0 = r1;
            r1 = tr;
            s0 = s1;
            s1 = ts;
        end
        if (s0 < 0)
            s0 = s0 + longint'(md);
        return crt_pkg::WIDE_W'(s0) % md;
    endfunction

    function automatic crt_answer_t solve_pair(logic [crt_pkg::IN_DATA_W-1:0] beat);
        logic [crt_pkg::WIDE_W-1:0] a, n, b, m, g, nr, mr, d, t;
        crt_answer_t res;
        a = beat[0 +: crt_pkg::FIELD_W];
        n = beat[crt_pkg::FIELD_W +: crt_pkg::FIELD_W];
        b = beat[2*crt_pkg::FIELD_W +: crt_pkg::FIELD_W];
        m = beat[3*crt_pkg::FIELD_W +: crt_pkg::FIELD_W];
        if (n == 0)
            n = 1;
        if (m == 0)
            m = 1;
        a = a % n;
        b = b % m;
        g = gcd64(n, m);
        nr = n / g;
        mr = m / g;
        res.lcm = n * mr;
        if ((a % g) != (b % g))
        begin
            res.solution = 0;
            res.solvable = 1'b0;
            return res;
        end
        if (b >= a)
            d = ((b - a) / g) % mr;
        else
            d = (mr - (((a - b) / g) % mr)) % mr;
        t = (d * mod_inverse(nr, mr)) % mr;
        res.solution = a + n * t;
        res.solvable = 1'b1;
        return res;
    endfunction

    assign pending = answers.size();

    always @(posedge clk or negedge rst_n)
    begin
        crt_answer_t want;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                answers = {answers, solve_pair(s_axis_tdata)};
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if (m_axis_tdata[0 +: crt_pkg::WIDE_W] !== want.solution ||
                        m_axis_tuser[0] !== want.solvable ||
                        m_axis_tdata[crt_pkg::WIDE_W +: crt_pkg::WIDE_W] !== want.lcm)
                    begin
                        $display("%0t: expected x=%0d ok=%0d lcm=%0d, got x=%0d ok=%0d lcm=%0d",
                                 $time, want.solution, want.solvable, want.lcm,
                                 m_axis_tdata[0 +: crt_pkg::WIDE_W], m_axis_tuser[0],
                                 m_axis_tdata[crt_pkg::WIDE_W +: crt_pkg::WIDE_W]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_two_moduli_crt_solver_core.sv
`timescale 1ns / 1ps
// Testbench top for the two-moduli CRT solver: clock, reset, stimulus, verdict.
// Depends on crt_pkg, two_moduli_crt_solver_core and crt_scoreboard.
module tb_two_moduli_crt_solver_core;

    localparam int N_RANDOM   = 400;
    localparam int STALL_STOP = 340;
    localparam int WATCHDOG   = 40000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [crt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                     m_axis_tuser;
    int                             errors;
    int                             pending;
    int                             quiet = 0;
    int                             stall_left = 0;
    bit                             calm = 1'b0;

    always #5 clk = ~clk;

    two_moduli_crt_solver_core dut (.*);

    crt_scoreboard checker_i (.*);

    function automatic logic [crt_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: return $urandom_range(1, 1000);
            3: return $urandom_range(1, 65535);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [crt_pkg::IN_DATA_W-1:0] random_pair();
        logic [crt_pkg::FIELD_W-1:0] n, m, g, a, b;
        g = 1;
        n = pick_value();
        m = pick_value();
        // Mostly shared factors so that both solvable and unsolvable pairs show up.
        if ($urandom_range(0, 2) != 0)
        begin
            g = $urandom_range(1, 4000);
            n = g * $urandom_range(1, 60000);
            m = g * $urandom_range(1, 60000);
        end
        a = pick_value();
        b = ($urandom_range(0, 1) == 1) ? a + (g * $urandom_range(0, 1000)) : pick_value();
        return {m, b, n, a};
    endfunction

    task automatic send_beat(input logic [crt_pkg::IN_DATA_W-1:0] beat);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end
        else
            m_axis_tready <= rst_n;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [crt_pkg::IN_DATA_W-1:0] directed[$];
        directed = '{
            {32'd5, 32'd2, 32'd3, 32'd1},
            {32'd0, 32'd0, 32'd0, 32'd0},
            {32'd1, 32'd7, 32'd0, 32'd9},
            {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            {32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFE, 32'h8765_4321},
            {32'hFFFF_FFFB, 32'd3, 32'hFFFF_FFFF, 32'd10},
            {32'd6, 32'd2, 32'd4, 32'd1},
            {32'd6, 32'd3, 32'd4, 32'd1},
            {32'd12, 32'd5, 32'd4, 32'd3},
            {32'd4, 32'd5, 32'd12, 32'd1},
            {32'd1, 32'd0, 32'd7, 32'd3},
            {32'd7, 32'd3, 32'd1, 32'd0},
            {32'h8000_0000, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h5555_5555},
            {32'hFFFF_FFFB, 32'h0, 32'hFFFF_FFFD, 32'h1}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_beat(directed[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == STALL_STOP)
                calm = 1'b1;
            send_beat(random_pair());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: two_moduli_crt_solver_core.f
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/crt_datapath.sv
rtl/crt_ctrl.sv
rtl/two_moduli_crt_solver_core.sv
rtl/crt_checker.sv
tb/crt_scoreboard.sv
tb/tb_two_moduli_crt_solver_core.sv
